FILE: src/smtr_pkg.sv
// ----------------------------------------------------------------------------
// smtr_pkg: shared definitions for the stereo multi-tap reverb
// Default sizes, field widths, register and request codes, and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package smtr_pkg;

	localparam int HISTORY_DEPTH_DEF = 65536;
	localparam int MAX_TAPS_DEF      = 512;
	localparam int SAMPLE_BITS_DEF   = 16;

	localparam int DELAY_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int TAP_IDX_W  = 9;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SAME_TAPS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OPPO_TAPS = 1'b1;

	// Request kinds carried on tuser.
	localparam logic REQ_AUDIO = 1'b0;
	localparam logic REQ_TAP   = 1'b1;

	// Tap table selection.
	localparam logic SIDE_SAME = 1'b0;
	localparam logic SIDE_OPPO = 1'b1;

	typedef struct packed {
		logic tap_wr;      // write the tap entry carried by the request
		logic frame_start; // store the frame in history and seed the accumulators
		logic tap_rd;      // read one tap entry and send it down the pipeline
		logic rd_side;     // table of that tap read
		logic load_out;    // round, saturate and load the output register
	} smtr_cmd_t;

	typedef struct packed {
		logic pipe_busy;   // a tap is still in flight in the datapath
	} smtr_stat_t;

endpackage

FILE: src/smtr_ram.sv
// ----------------------------------------------------------------------------
// smtr_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module smtr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/smtr_ctrl.sv
// ----------------------------------------------------------------------------
// smtr_ctrl: request sequencer of the stereo multi-tap reverb
// Holds the tap count registers, takes requests, walks the same-side and
// then the opposite-side tap table, and hands the result to the output.
// ----------------------------------------------------------------------------
module smtr_ctrl #(
	parameter int MAX_TAPS = smtr_pkg::MAX_TAPS_DEF,
	localparam int CNT_W = $clog2(MAX_TAPS + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic                             req_type,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic                             cfg_we,
	input  logic [smtr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smtr_pkg::CFG_DATA_W-1:0] cfg_data,
	output smtr_pkg::smtr_cmd_t              cmd,
	output logic [CNT_W-1:0]                 rd_idx,
	input  smtr_pkg::smtr_stat_t             stat
);
	import smtr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_WALK   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t                state_q, state_d;
	logic [CFG_DATA_W-1:0] same_used_q, oppo_used_q;
	logic [CNT_W-1:0]      idx_q, idx_d;
	logic [CNT_W-1:0]      same_cnt, oppo_cnt, cur_cnt;
	logic                  side_q, side_d;
	logic                  m_tvalid_q, m_tvalid_d;
	logic                  s_fire;

	// Counts above the table size act as the table size.
	assign same_cnt = (32'(same_used_q) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(same_used_q);
	assign oppo_cnt = (32'(oppo_used_q) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(oppo_used_q);
	assign cur_cnt  = (side_q == SIDE_SAME) ? same_cnt : oppo_cnt;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign rd_idx   = idx_q;

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		side_d     = side_q;
		m_tvalid_d = m_tvalid_q && !m_tready;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					if (req_type == REQ_TAP) begin
						cmd.tap_wr = 1'b1;
					end else begin
						cmd.frame_start = 1'b1;
						idx_d           = '0;
						side_d          = SIDE_SAME;
						state_d         = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (idx_q < cur_cnt) begin
					cmd.tap_rd  = 1'b1;
					cmd.rd_side = side_q;
					idx_d       = idx_q + 1'b1;
				end else if (side_q == SIDE_SAME) begin
					side_d = SIDE_OPPO;
					idx_d  = '0;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					m_tvalid_d   = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			side_q      <= SIDE_SAME;
			m_tvalid_q  <= 1'b0;
			same_used_q <= '0;
			oppo_used_q <= '0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			side_q     <= side_d;
			m_tvalid_q <= m_tvalid_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SAME_TAPS: same_used_q <= cfg_data;
					REG_OPPO_TAPS: oppo_used_q <= cfg_data;
				endcase
			end
		end
	end

endmodule

FILE: src/smtr_datapath.sv
// ----------------------------------------------------------------------------
// smtr_datapath: history, tap tables and multiply-accumulate pipeline
// Taps flow through table read, history read, multiply and accumulate.
// ----------------------------------------------------------------------------
module smtr_datapath #(
	parameter int HISTORY_DEPTH = smtr_pkg::HISTORY_DEPTH_DEF,
	parameter int MAX_TAPS      = smtr_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS   = smtr_pkg::SAMPLE_BITS_DEF,
	localparam int CNT_W = $clog2(MAX_TAPS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  smtr_pkg::smtr_cmd_t             cmd,
	input  logic [CNT_W-1:0]                rd_idx,
	output smtr_pkg::smtr_stat_t            stat,
	input  logic signed [SAMPLE_BITS-1:0]   sample_left,
	input  logic signed [SAMPLE_BITS-1:0]   sample_right,
	input  logic                            tap_side,
	input  logic [smtr_pkg::TAP_IDX_W-1:0]  tap_index,
	input  logic [smtr_pkg::DELAY_W-1:0]    tap_delay,
	input  logic [smtr_pkg::GAIN_W-1:0]     tap_gain,
	output logic signed [SAMPLE_BITS-1:0]   out_left,
	output logic signed [SAMPLE_BITS-1:0]   out_right
);
	import smtr_pkg::*;

	localparam int HW        = $clog2(HISTORY_DEPTH);
	localparam int FW        = HW + 1;
	localparam int XW        = HW + DELAY_W + 1;
	localparam int TAP_AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int TAP_DEPTH = 2 << TAP_AW;
	localparam int TAP_W     = DELAY_W + GAIN_W;
	localparam int HIST_W    = 2 * SAMPLE_BITS;
	localparam int PROD_W    = SAMPLE_BITS + GAIN_W + 1;
	localparam int ACC_W     = SAMPLE_BITS + GAIN_W + 2 + $clog2(2 * MAX_TAPS + 1);
	localparam int Q_W       = ACC_W - GAIN_W;
	localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-(2 ** (SAMPLE_BITS - 1)));

	function automatic logic [SAMPLE_BITS-1:0] sat(input logic signed [Q_W-1:0] q);
		logic [SAMPLE_BITS-1:0] r;
		if (q > Q_MAX) begin
			r = Q_MAX[SAMPLE_BITS-1:0];
		end else if (q < Q_MIN) begin
			r = Q_MIN[SAMPLE_BITS-1:0];
		end else begin
			r = q[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

	logic [HW-1:0]     wp_q;
	logic [FW-1:0]     fill_q;
	logic              v_s1, v_s2, v_s3;
	logic              side_s1, side_s2;
	logic [GAIN_W-1:0] gain_s2;
	logic signed [PROD_W-1:0] prod_l_s3, prod_r_s3;
	logic signed [ACC_W-1:0]  acc_l_q, acc_r_q;
	logic [SAMPLE_BITS-1:0]   out_left_q, out_right_q;

	logic              tap_we;
	logic [TAP_AW:0]   tap_waddr, tap_raddr;
	logic [TAP_W-1:0]  tap_rdata;
	logic [DELAY_W-1:0] tap_delay_rd;
	logic [GAIN_W-1:0] tap_gain_rd;
	logic              in_range;
	logic [XW-1:0]     wp_x, d_x, hist_addr_x;
	logic [HW-1:0]     hist_addr;
	logic [HIST_W-1:0] hist_rdata;
	logic signed [SAMPLE_BITS-1:0] hist_l, hist_r, src_l, src_r;
	logic signed [GAIN_W:0]        gain_x;
	logic signed [ACC_W-1:0]       dry_l, dry_r, rnd_l, rnd_r;
	logic signed [Q_W-1:0]         q_l, q_r;

	// Both tap tables share one memory, the table bit on top of the address.
	assign tap_we    = cmd.tap_wr && (32'(tap_index) < MAX_TAPS);
	assign tap_waddr = {tap_side, TAP_AW'(tap_index)};
	assign tap_raddr = {cmd.rd_side, TAP_AW'(rd_idx)};

	smtr_ram #(
		.WIDTH (TAP_W),
		.DEPTH (TAP_DEPTH)
	) u_tap_ram (
		.clk   (clk),
		.we    (tap_we),
		.waddr (tap_waddr),
		.wdata ({tap_delay, tap_gain}),
		.re    (cmd.tap_rd),
		.raddr (tap_raddr),
		.rdata (tap_rdata)
	);

	// Stage 1: the tap entry is out. A delay reaching past the frames stored
	// so far is caught by the fill count, so its gain is dropped.
	assign tap_delay_rd = tap_rdata[TAP_W-1:GAIN_W];
	assign tap_gain_rd  = tap_rdata[GAIN_W-1:0];
	assign wp_x         = XW'(wp_q);
	assign d_x          = XW'(tap_delay_rd);
	assign in_range     = d_x < XW'(fill_q);
	assign hist_addr_x  = (wp_x >= d_x) ? (wp_x - d_x) : (wp_x + XW'(HISTORY_DEPTH) - d_x);
	assign hist_addr    = hist_addr_x[HW-1:0];

	smtr_ram #(
		.WIDTH (HIST_W),
		.DEPTH (HISTORY_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (cmd.frame_start),
		.waddr (wp_q),
		.wdata ({sample_right, sample_left}),
		.re    (v_s1),
		.raddr (hist_addr),
		.rdata (hist_rdata)
	);

	// Stage 2: history pair is out; crossfeed taps swap the channels.
	assign hist_l = hist_rdata[SAMPLE_BITS-1:0];
	assign hist_r = hist_rdata[HIST_W-1:SAMPLE_BITS];
	assign src_l  = (side_s2 == SIDE_SAME) ? hist_l : hist_r;
	assign src_r  = (side_s2 == SIDE_SAME) ? hist_r : hist_l;
	assign gain_x = $signed({1'b0, gain_s2});

	assign dry_l = ACC_W'(sample_left);
	assign dry_r = ACC_W'(sample_right);

	// Round half up, then floor by the gain fraction.
	assign rnd_l = acc_l_q + ACC_W'(2 ** (GAIN_W - 1));
	assign rnd_r = acc_r_q + ACC_W'(2 ** (GAIN_W - 1));
	assign q_l   = $signed(rnd_l[ACC_W-1:GAIN_W]);
	assign q_r   = $signed(rnd_r[ACC_W-1:GAIN_W]);

	assign stat.pipe_busy = v_s1 || v_s2 || v_s3;
	assign out_left       = out_left_q;
	assign out_right      = out_right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			v_s1 <= cmd.tap_rd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.frame_start && (fill_q != FW'(HISTORY_DEPTH))) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.load_out) begin
				wp_q <= (wp_q == HW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s1   <= cmd.rd_side;
		side_s2   <= side_s1;
		gain_s2   <= in_range ? tap_gain_rd : '0;
		prod_l_s3 <= src_l * gain_x;
		prod_r_s3 <= src_r * gain_x;
		if (cmd.frame_start) begin
			acc_l_q <= dry_l <<< GAIN_W;
			acc_r_q <= dry_r <<< GAIN_W;
		end else if (v_s3) begin
			acc_l_q <= acc_l_q + prod_l_s3;
			acc_r_q <= acc_r_q + prod_r_s3;
		end
		if (cmd.load_out) begin
			out_left_q  <= sat(q_l);
			out_right_q <= sat(q_r);
		end
	end

endmodule

FILE: src/stereo_multitap_reverb_unit.sv
// ----------------------------------------------------------------------------
// stereo_multitap_reverb_unit: stereo feed-forward multi-tap reverb
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// Each audio request (tuser low) stores its stereo frame in a history memory
// and returns one result: every channel is its own dry sample plus the
// gain-weighted sum of past samples, same-side taps reading the channel
// itself and crossfeed taps reading the other one, rounded half up and
// saturated to the sample width. A tap write request (tuser high) loads one
// entry of a tap table and returns nothing. An audio request occupies the
// block while the controller walks the same-side and then the crossfeed
// taps (counts clamped to MAX_TAPS), waits for the pipeline to drain and,
// once the output is free, loads the output register. The history memory
// has a single read port and gives one tap per cycle while a table is
// walked; the multiply-accumulate pipeline around it is four stages deep:
// table read, history read, multiply and accumulate. History entries not
// yet written since reset read as zero through a fill count, so the block
// needs no clearing pass and is ready right after reset. Tap entries must
// be written before a tap count covers them. A new request is taken while
// the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module stereo_multitap_reverb_unit #(
	parameter int HISTORY_DEPTH = smtr_pkg::HISTORY_DEPTH_DEF,
	parameter int MAX_TAPS      = smtr_pkg::MAX_TAPS_DEF,
	parameter int SAMPLE_BITS   = smtr_pkg::SAMPLE_BITS_DEF,
	localparam int IN_W  = ((2 * SAMPLE_BITS + smtr_pkg::TAP_IDX_W + smtr_pkg::DELAY_W
		+ smtr_pkg::GAIN_W + 1 + 7) / 8) * 8,
	localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// sample_left, sample_right, tap_side, tap_index, tap_delay, tap_gain
	input  logic [IN_W-1:0]                  s_tdata,
	// req_type
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_left, out_right
	output logic [OUT_W-1:0]                 m_tdata,
	input  logic                             cfg_we,
	input  logic [smtr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smtr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import smtr_pkg::*;

	localparam int CNT_W    = $clog2(MAX_TAPS + 1);
	localparam int OFS_SIDE = 2 * SAMPLE_BITS;
	localparam int OFS_IDX  = OFS_SIDE + 1;
	localparam int OFS_DLY  = OFS_IDX + TAP_IDX_W;
	localparam int OFS_GAIN = OFS_DLY + DELAY_W;

	smtr_cmd_t  cmd;
	smtr_stat_t stat;
	logic [CNT_W-1:0] rd_idx;

	logic signed [SAMPLE_BITS-1:0] sample_left, sample_right;
	logic signed [SAMPLE_BITS-1:0] out_left, out_right;
	logic                          tap_side;
	logic [TAP_IDX_W-1:0]          tap_index;
	logic [DELAY_W-1:0]            tap_delay;
	logic [GAIN_W-1:0]             tap_gain;

	// Unpack the request; the same bits serve audio and tap writes.
	assign sample_left  = s_tdata[SAMPLE_BITS-1:0];
	assign sample_right = s_tdata[OFS_SIDE-1:SAMPLE_BITS];
	assign tap_side     = s_tdata[OFS_SIDE];
	assign tap_index    = s_tdata[OFS_DLY-1:OFS_IDX];
	assign tap_delay    = s_tdata[OFS_GAIN-1:OFS_DLY];
	assign tap_gain     = s_tdata[OFS_GAIN+GAIN_W-1:OFS_GAIN];

	// Results are packed left first, padded with zeros to whole bytes.
	assign m_tdata = OUT_W'({out_right, out_left});

	smtr_ctrl #(
		.MAX_TAPS (MAX_TAPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.req_type  (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.rd_idx    (rd_idx),
		.stat      (stat)
	);

	smtr_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.MAX_TAPS      (MAX_TAPS),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.rd_idx       (rd_idx),
		.stat         (stat),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.tap_side     (tap_side),
		.tap_index    (tap_index),
		.tap_delay    (tap_delay),
		.tap_gain     (tap_gain),
		.out_left     (out_left),
		.out_right    (out_right)
	);

`ifndef SYNTHESIS
	// An audio request occupies the block, so the input closes right after it.
	a_audio_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == REQ_AUDIO) |=> !s_tready)
		else $error("input still open after an audio request");

	// A tap write does not occupy the block and leaves the input open.
	a_tap_quick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == REQ_TAP) |=> s_tready)
		else $error("input closed after a tap write");

	// A result is only presented once every tap has been accumulated.
	a_result_drained: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !stat.pipe_busy)
		else $error("result presented with taps still in flight");
`endif

endmodule

FILE: verif/stereo_multitap_reverb_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_multitap_reverb_unit_test: regression bench for the multi-tap reverb
// Drives audio and tap write requests on the input stream, sets the tap
// counts through the configuration port while the block is idle, and checks
// every stereo result against a bit-exact prediction of the reverb mix.
// ----------------------------------------------------------------------------
module stereo_multitap_reverb_unit_test;
	import smtr_pkg::*;

	localparam int HIST_DEPTH = HISTORY_DEPTH_DEF;
	localparam int TAPS       = MAX_TAPS_DEF;
	localparam int HIST_W     = $clog2(HIST_DEPTH);
	localparam int IN_W       = ((2 * SAMPLE_BITS_DEF + TAP_IDX_W + DELAY_W + GAIN_W + 1 + 7)
		/ 8) * 8;
	localparam int OUT_W      = ((2 * SAMPLE_BITS_DEF + 7) / 8) * 8;

	// After the last result only a tap write can still be in flight.
	localparam int SETTLE_CYCLES   = 16;
	// At the end, wait out a full-table frame so that a stray result shows up.
	localparam int END_CYCLES      = 2 * TAPS + 32;
	localparam int HOLD_OFF_CYCLES = 2500;
	localparam int PHASES          = 10;
	localparam int PHASE_ITEMS     = 50;
	// Worst case is far below this, even with every stall.
	localparam int TIMEOUT_NS      = 10_000_000;

	// One request on the input stream, all fields at the block's widths.
	typedef struct {
		logic                  kind;
		logic signed [15:0]    left;
		logic signed [15:0]    right;
		logic                  side;
		logic [TAP_IDX_W-1:0]  index;
		logic [DELAY_W-1:0]    delay;
		logic [GAIN_W-1:0]     gain;
	} reverb_req_t;

	typedef struct {
		shortint left;
		shortint right;
	} stereo_out_t;

	// Tracks the history rings, tap tables and tap counts, and holds the
	// stereo results still to come from the block, oldest first.
	class reverb_scoreboard;
		shortint          hist_left[HIST_DEPTH];
		shortint          hist_right[HIST_DEPTH];
		bit [HIST_W-1:0]  frame_ptr;
		bit [DELAY_W-1:0] same_delay[TAPS];
		bit [GAIN_W-1:0]  same_gain[TAPS];
		bit [DELAY_W-1:0] oppo_delay[TAPS];
		bit [GAIN_W-1:0]  oppo_gain[TAPS];
		int               same_count;
		int               oppo_count;
		stereo_out_t      pending_mix[$];
		int               mismatches;
		int               frames_noted;
		int               taps_noted;

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $time, what);
			mismatches++;
		endtask

		function void set_count(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_SAME_TAPS) begin
				same_count = value;
			end else if (idx == REG_OPPO_TAPS) begin
				oppo_count = value;
			end
		endfunction

		// Gain-weighted sum of the first count taps of one table over one ring.
		function longint tap_sum(bit from_right, bit crossfeed, int count);
			longint           acc;
			bit [HIST_W-1:0]  slot;
			bit [GAIN_W-1:0]  g;
			shortint          s;
			acc = 0;
			for (int i = 0; i < count; i++) begin
				slot = crossfeed ? frame_ptr - oppo_delay[i] : frame_ptr - same_delay[i];
				g    = crossfeed ? oppo_gain[i] : same_gain[i];
				s    = from_right ? hist_right[slot] : hist_left[slot];
				acc += longint'(s) * longint'(g);
			end
			return acc;
		endfunction

		// Round half up (floor after adding one half) and saturate to Q1.15.
		function shortint round_sat(longint acc);
			longint q;
			q = (acc + 64'sd32768) >>> 16;
			if (q > 32767) begin
				q = 32767;
			end else if (q < -32768) begin
				q = -32768;
			end
			return shortint'(q);
		endfunction

		function void note_request(reverb_req_t r);
			int          ns;
			int          no;
			stereo_out_t mix;
			if (r.kind == REQ_TAP) begin
				if (r.side == SIDE_OPPO) begin
					oppo_delay[r.index] = r.delay;
					oppo_gain[r.index]  = r.gain;
				end else begin
					same_delay[r.index] = r.delay;
					same_gain[r.index]  = r.gain;
				end
				taps_noted++;
				return;
			end
			hist_left[frame_ptr]  = r.left;
			hist_right[frame_ptr] = r.right;
			ns = (same_count > TAPS) ? TAPS : same_count;
			no = (oppo_count > TAPS) ? TAPS : oppo_count;
			mix.left  = round_sat(longint'(shortint'(r.left)) * 65536
				+ tap_sum(1'b0, 1'b0, ns) + tap_sum(1'b1, 1'b1, no));
			mix.right = round_sat(longint'(shortint'(r.right)) * 65536
				+ tap_sum(1'b1, 1'b0, ns) + tap_sum(1'b0, 1'b1, no));
			pending_mix = {pending_mix, mix};
			frame_ptr++;
			frames_noted++;
		endfunction

		task check_frame(logic [OUT_W-1:0] data);
			stereo_out_t want;
			if (pending_mix.size() == 0) begin
				report_mismatch($sformatf("result %h arrived with none expected", data));
				return;
			end
			want = pending_mix.pop_front();
			if (data[15:0] !== 16'(want.left)) begin
				report_mismatch($sformatf("out_left %h, expected %h", data[15:0],
					16'(want.left)));
			end
			if (data[31:16] !== 16'(want.right)) begin
				report_mismatch($sformatf("out_right %h, expected %h", data[31:16],
					16'(want.right)));
			end
		endtask
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// sample_left, sample_right, tap_side, tap_index, tap_delay, tap_gain
	logic [IN_W-1:0]       s_tdata   = '0;
	// req_type
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// out_left, out_right
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	reverb_scoreboard sb = new();

	// Which tap entries hold a written value; a tap count may only cover these.
	bit same_loaded[TAPS];
	bit oppo_loaded[TAPS];

	bit calm_sender;
	int hold_off_left;
	int rx_cycles;
	int count_settings;

	stereo_multitap_reverb_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Receiver side. A requested hold-off is counted down here, cycle by
	// cycle, so the sender keeps pushing until the block backs up. Outside
	// that, a recurring window is kept free of stalls and the rest drops
	// ready in about 15 percent of cycles.
	always @(negedge clk) begin
		rx_cycles++;
		if (hold_off_left > 0) begin
			m_tready <= 1'b0;
			hold_off_left--;
		end else if (rx_cycles % 6000 < 1200) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 15);
		end
	end

	// Every accepted result goes straight to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_frame(m_tdata);
		end
	end

	// Offers one request, with a random gap in front of it now and then, and
	// hands it to the scoreboard at the edge where it is accepted. Valid stays
	// high after acceptance; the next call or settle_block replaces or drops it.
	task automatic push_request(input reverb_req_t r);
		if (!calm_sender && $urandom_range(99) < 15) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= r.kind;
		s_tdata  <= IN_W'({r.gain, r.delay, r.index, r.side, r.right, r.left});
		do @(posedge clk); while (!s_tready);
		sb.note_request(r);
	endtask

	// Audio request; the tap fields ride along with random content.
	task automatic send_frame(input shortint left, input shortint right);
		reverb_req_t r;
		r.kind  = REQ_AUDIO;
		r.left  = left;
		r.right = right;
		r.side  = 1'($urandom_range(0, 1));
		r.index = TAP_IDX_W'($urandom);
		r.delay = DELAY_W'($urandom);
		r.gain  = GAIN_W'($urandom);
		push_request(r);
	endtask

	// Tap write request; the sample fields ride along with random content.
	task automatic load_tap(input logic side, input int idx, input int dly, input int gn);
		reverb_req_t r;
		r.kind  = REQ_TAP;
		r.left  = 16'($urandom);
		r.right = 16'($urandom);
		r.side  = side;
		r.index = TAP_IDX_W'(idx);
		r.delay = DELAY_W'(dly);
		r.gain  = GAIN_W'(gn);
		if (side == SIDE_OPPO) begin
			oppo_loaded[idx] = 1'b1;
		end else begin
			same_loaded[idx] = 1'b1;
		end
		push_request(r);
	endtask

	// Drops valid, waits for every expected result, then lets a possible tap
	// write finish so that the tap counts can be changed safely.
	task automatic settle_block();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_mix.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_count(idx, value);
	endtask

	task automatic set_tap_counts(input int ns, input int no);
		settle_block();
		write_count(REG_SAME_TAPS, CFG_DATA_W'(ns));
		write_count(REG_OPPO_TAPS, CFG_DATA_W'(no));
		count_settings++;
	endtask

	// Makes sure the first n entries of one table are written before a
	// count of n is set.
	task automatic fill_taps(input logic side, input int n);
		for (int i = 0; i < n && i < TAPS; i++) begin
			if (side == SIDE_OPPO ? !oppo_loaded[i] : !same_loaded[i]) begin
				load_tap(side, i, pick_delay(), pick_gain());
			end
		end
	endtask

	// Extremes, small values around zero, and full-range noise.
	function automatic shortint pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2, 3, 4: return shortint'($urandom_range(0, 2000)) - 16'sd1000;
			default: return shortint'($urandom);
		endcase
	endfunction

	// Mostly short delays of up to 80 frames; the rest span the full delay
	// range and may reach back past the first frame, where history counts as zero.
	function automatic int pick_delay();
		if ($urandom_range(99) < 75) begin
			return $urandom_range(0, 80);
		end
		return $urandom_range(0, 65535);
	endfunction

	function automatic int pick_gain();
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(0, 255);
			2, 3, 4, 5, 6: return $urandom_range(0, 8192);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("stereo_multitap_reverb_unit regression: fail");
		$finish;
	end

	initial begin : main_flow
		int ns;
		int no;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// With both counts at their reset value of zero the block passes the
		// audio straight through; the tap fields here carry random content and
		// must have no effect.
		send_frame(16'sd0, 16'sd0);
		send_frame(16'sh7fff, 16'sh8000);
		send_frame(16'sh8000, 16'sh7fff);
		send_frame(-16'sd1, 16'sd1);

		// Directed taps: the current frame at full and half gain, a delay far
		// beyond the frames seen so far, a one-unit gain, a zero gain, and
		// the top table entry on both sides.
		load_tap(SIDE_SAME, 0, 0, 65535);
		load_tap(SIDE_OPPO, 0, 0, 32768);
		load_tap(SIDE_SAME, 1, 65535, 65535);
		load_tap(SIDE_OPPO, 1, 2, 1);
		load_tap(SIDE_SAME, 2, 1, 32768);
		load_tap(SIDE_OPPO, 2, 3, 0);
		load_tap(SIDE_SAME, TAPS - 1, 0, 0);
		load_tap(SIDE_OPPO, TAPS - 1, 65535, 65535);

		// Full-scale input with strong taps drives both rails into
		// saturation; small values exercise rounding of half-unit products.
		set_tap_counts(3, 3);
		send_frame(16'sh7fff, 16'sh7fff);
		send_frame(16'sh8000, 16'sh8000);
		send_frame(16'sd1, -16'sd1);
		send_frame(16'sd0, 16'sd0);
		send_frame(16'sd12345, -16'sd23456);

		// Random part: each phase picks fresh tap counts, writes any entries
		// those counts newly cover, then mixes audio with tap rewrites.
		for (int phase = 0; phase < PHASES; phase++) begin
			ns = $urandom_range(0, 40);
			no = $urandom_range(0, 40);
			fill_taps(SIDE_SAME, ns);
			fill_taps(SIDE_OPPO, no);
			set_tap_counts(ns, no);
			calm_sender = (phase == 7);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (phase == 3 && k == 5) begin
					hold_off_left = HOLD_OFF_CYCLES;
				end
				if ($urandom_range(99) < 80) begin
					send_frame(pick_sample(), pick_sample());
				end else begin
					load_tap(1'($urandom_range(0, 1)), $urandom_range(0, TAPS - 1),
						pick_delay(), pick_gain());
				end
			end
		end
		calm_sender = 1'b0;

		settle_block();
		repeat (END_CYCLES) @(posedge clk);

		$display("Covered %0d audio frames and %0d tap writes over %0d tap-count settings.",
			sb.frames_noted, sb.taps_noted, count_settings);
		$display("Run included saturation, pass-through and a %0d-cycle output stall; %0d %s",
			HOLD_OFF_CYCLES, sb.mismatches, "mismatches.");
		if (sb.mismatches == 0) begin
			$display("stereo_multitap_reverb_unit regression: pass");
		end else begin
			$display("stereo_multitap_reverb_unit regression: fail");
		end
		$finish;
	end

endmodule

FILE: stereo_multitap_reverb_unit.f
src/smtr_pkg.sv
src/smtr_ram.sv
src/smtr_ctrl.sv
src/smtr_datapath.sv
src/stereo_multitap_reverb_unit.sv
verif/stereo_multitap_reverb_unit_test.sv
